@@ design/ipa_pkg.sv @@
// Shared types and constants for the interrupt pending arbiter.
// Holds the action and status codes and the fixed group geometry.
// No dependencies.
package ipa_pkg;

  localparam int unsigned GroupW   = 32;
  localparam int unsigned GroupN   = 4;
  localparam int unsigned MaxSrc   = GroupW * GroupN;
  localparam int unsigned ActionW  = 3;
  localparam int unsigned IrqW     = 7;
  localparam int unsigned StatusW  = 2;

  typedef enum logic [ActionW-1:0] {
    ACT_ENABLE  = 3'd0,
    ACT_DISABLE = 3'd1,
    ACT_MASK    = 3'd2,
    ACT_UNMASK  = 3'd3,
    ACT_TAKE    = 3'd4
  } action_t;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_GROUP = 2'd1,
    ST_RANGE = 2'd2,
    ST_NONE  = 2'd3
  } status_t;

endpackage

@@ design/interrupt_pending_arbiter.sv @@
// A word accepted into the input register updates the allowed, mask and pending
// vectors combinationally and has its result captured in the result register as it advances.
// Throughput: one word per cycle while out_stall does not hold the result register.
// Reset (rst_n low, synchronous) clears allowed and pending, sets every mask
// bit and empties both register stages.
// Depends on ipa_pkg.
module interrupt_pending_arbiter #(
  parameter int unsigned SOURCE_COUNT = 96
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [2:0]                 in_action,
  input  logic [6:0]                 in_irq_number,
  input  logic                       in_mark_pending,
  output logic                       out_valid,
  input  logic                       out_stall,
  output ipa_pkg::status_t           out_status,
  output logic [6:0]                 out_taken_irq,
  output logic                       out_taken_valid
);
  import ipa_pkg::*;

  localparam int unsigned IdxW = $clog2(SOURCE_COUNT);

  logic                    s1_valid_r, s1_valid_nxt;
  logic [ActionW-1:0]      s1_action_r;
  logic [IrqW-1:0]         s1_irq_r;
  logic                    s1_mark_r;

  logic [SOURCE_COUNT-1:0] allow_r, allow_nxt;
  logic [SOURCE_COUNT-1:0] mask_r, mask_nxt;
  logic [SOURCE_COUNT-1:0] pend_r, pend_nxt;

  logic                    out_valid_r, out_valid_nxt;
  status_t                 out_status_r, status_nxt;
  logic [IrqW-1:0]         out_taken_irq_r, taken_irq_nxt;
  logic                    out_taken_valid_r, taken_valid_nxt;

  logic                    advance;
  logic [MaxSrc-1:0]       allow_ext;
  logic [GroupN-1:0]       grp_any;
  logic [SOURCE_COUNT-1:0] sel;
  logic                    out_of_range;
  logic                    found;
  logic [IrqW-1:0]         found_idx;

  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (!in_stall) begin
      s1_valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_action_r <= in_action;
      s1_irq_r    <= in_irq_number;
      s1_mark_r   <= in_mark_pending;
    end
  end

  assign allow_ext    = MaxSrc'(allow_r);
  assign sel          = SOURCE_COUNT'(1) << s1_irq_r[IdxW-1:0];
  assign out_of_range = ({1'b0, s1_irq_r} >= (IrqW + 1)'(SOURCE_COUNT));

  always_comb begin
    for (int g = 0; g < GroupN; g++) begin
      grp_any[g] = |allow_ext[g*GroupW +: GroupW];
    end
  end

  always_comb begin
    found     = 1'b0;
    found_idx = '0;
    for (int i = 0; i < SOURCE_COUNT; i++) begin
      if (pend_r[i]) begin
        found     = 1'b1;
        found_idx = IrqW'(i);
      end
    end
  end

  always_comb begin
    allow_nxt       = allow_r;
    mask_nxt        = mask_r;
    pend_nxt        = pend_r;
    status_nxt      = ST_OK;
    taken_irq_nxt   = '0;
    taken_valid_nxt = 1'b0;
    if (s1_action_r <= ACT_UNMASK && out_of_range) begin
      status_nxt = ST_RANGE;
    end else begin
      unique case (s1_action_r)
        ACT_ENABLE: begin
          allow_nxt = allow_r | sel;
          mask_nxt  = mask_r & ~sel;
        end
        ACT_DISABLE: begin
          allow_nxt = allow_r & ~sel;
          mask_nxt  = mask_r | sel;
        end
        ACT_MASK: begin
          if (!grp_any[s1_irq_r[IrqW-1:IrqW-2]]) begin
            status_nxt = ST_GROUP;
          end else begin
            mask_nxt = mask_r | sel;
            if (s1_mark_r) begin
              pend_nxt = pend_r | sel;
            end
          end
        end
        ACT_UNMASK: begin
          if (!grp_any[s1_irq_r[IrqW-1:IrqW-2]]) begin
            status_nxt = ST_GROUP;
          end else begin
            mask_nxt = mask_r & ~sel;
          end
        end
        ACT_TAKE: begin
          if (found) begin
            pend_nxt        = pend_r & ~(SOURCE_COUNT'(1) << found_idx[IdxW-1:0]);
            taken_irq_nxt   = found_idx;
            taken_valid_nxt = 1'b1;
          end else begin
            status_nxt = ST_NONE;
          end
        end
        default: begin
          status_nxt = ST_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      allow_r <= '0;
      mask_r  <= '1;
      pend_r  <= '0;
    end else if (advance) begin
      allow_r <= allow_nxt;
      mask_r  <= mask_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_status_r      <= status_nxt;
      out_taken_irq_r   <= taken_irq_nxt;
      out_taken_valid_r <= taken_valid_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_taken_irq   = out_taken_irq_r;
  assign out_taken_valid = out_taken_valid_r;

endmodule

@@ design/ipa_checker.sv @@
// Port-level checks for the interrupt pending arbiter, bound to the top level.
// Depends on ipa_pkg and interrupt_pending_arbiter.
module ipa_checker #(
  parameter int unsigned SOURCE_COUNT = 96
) (
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_stall,
  input ipa_pkg::status_t out_status,
  input logic [6:0]       out_taken_irq,
  input logic             out_taken_valid
);
  import ipa_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) &&
      $stable(out_taken_irq) && $stable(out_taken_valid))
    else $error("Stalled result word changed.");

  a_taken_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_taken_valid |-> out_status == ST_OK)
    else $error("Taken source reported with a non-ok status.");

  a_taken_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_taken_valid |-> out_taken_irq == '0)
    else $error("Source number given without a taken source.");

  a_taken_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_taken_valid |-> {1'b0, out_taken_irq} < 8'(SOURCE_COUNT))
    else $error("Taken source lies beyond the source count.");

endmodule

bind interrupt_pending_arbiter ipa_checker #(
  .SOURCE_COUNT(SOURCE_COUNT)
) u_ipa_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_status     (out_status),
  .out_taken_irq  (out_taken_irq),
  .out_taken_valid(out_taken_valid)
);

@@ sim/interrupt_pending_arbiter_tb.sv @@
// Self-checking testbench for the interrupt pending arbiter: a directed table,
// then random words under several idle and stall mixes, checked by a predictor.
// Depends on ipa_pkg and interrupt_pending_arbiter.
module interrupt_pending_arbiter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ipa_pkg::*;

  localparam int unsigned SrcCount   = 96;
  localparam int unsigned IrqMax     = (1 << IrqW) - 1;
  localparam logic [2:0]  ActSpareLo = 3'd5;
  localparam logic [2:0]  ActSpareHi = 3'd7;
  localparam int          PlanLen    = 25;
  localparam int          PhaseLen   = 300;
  localparam int          CycleLimit = 200000;

  typedef struct packed {
    status_t    status;
    logic [6:0] taken_irq;
    logic       taken_valid;
  } irq_result_t;

  typedef struct packed {
    logic [2:0]  act;
    logic [6:0]  irq;
    logic        mark;
    bit          typed;
    irq_result_t res;
  } plan_row_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [2:0] in_action;
  logic [6:0] in_irq_number;
  logic       in_mark_pending;
  logic       out_valid;
  logic       out_stall = 1'b0;
  status_t    out_status;
  logic [6:0] out_taken_irq;
  logic       out_taken_valid;

  logic [SrcCount-1:0] allowed_vec;
  logic [SrcCount-1:0] mask_vec;
  logic [SrcCount-1:0] pending_vec;

  irq_result_t result_q[$];
  plan_row_t   plan[PlanLen];
  int          mismatches = 0;
  int          cycles = 0;
  int          send_idle_pct;
  int          recv_stall_pct;

  interrupt_pending_arbiter #(
    .SOURCE_COUNT(SrcCount)
  ) i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_action      (in_action),
    .in_irq_number  (in_irq_number),
    .in_mark_pending(in_mark_pending),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_taken_irq  (out_taken_irq),
    .out_taken_valid(out_taken_valid)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Applies one word to the shadow vectors and returns what the block must answer.
  function automatic irq_result_t arbitrate(input logic [2:0] act, input logic [6:0] irq,
                                            input logic mark);
    irq_result_t r;
    int          grp;
    int          src;
    bit          found;
    r.status      = ST_OK;
    r.taken_irq   = '0;
    r.taken_valid = 1'b0;
    grp           = int'(irq[6:5]);
    found         = 1'b0;
    if (act <= ACT_UNMASK && irq >= SrcCount) begin
      r.status = ST_RANGE;
    end else begin
      case (act)
        ACT_ENABLE: begin
          allowed_vec[irq] = 1'b1;
          mask_vec[irq]    = 1'b0;
        end
        ACT_DISABLE: begin
          allowed_vec[irq] = 1'b0;
          mask_vec[irq]    = 1'b1;
        end
        ACT_MASK, ACT_UNMASK: begin
          if (allowed_vec[grp*GroupW +: GroupW] == '0) begin
            r.status = ST_GROUP;
          end else if (act == ACT_MASK) begin
            mask_vec[irq] = 1'b1;
            if (mark) pending_vec[irq] = 1'b1;
          end else begin
            mask_vec[irq] = 1'b0;
          end
        end
        ACT_TAKE: begin
          r.status = ST_NONE;
          for (src = SrcCount - 1; src >= 0 && !found; src--) begin
            if (pending_vec[src]) begin
              pending_vec[src] = 1'b0;
              r.status         = ST_OK;
              r.taken_irq      = src[6:0];
              r.taken_valid    = 1'b1;
              found            = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
    return r;
  endfunction

  // Presents one word, holds it until accepted and then queues its answer.
  task automatic send_word(input logic [2:0] act, input logic [6:0] irq, input logic mark,
                           input irq_result_t res);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_action       <= act;
    in_irq_number   <= irq;
    in_mark_pending <= mark;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    result_q.push_back(res);
  endtask

  always @(posedge clk) begin
    irq_result_t want;
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("%0t timeout with %0d results outstanding", $time, result_q.size());
      $display("*** FAILED ***");
      $finish;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (result_q.size() == 0) begin
        mismatches <= mismatches + 1;
        $display("%0t unexpected result: status %0d irq %0d valid %0d", $time, out_status,
                 out_taken_irq, out_taken_valid);
      end else begin
        want = result_q.pop_front();
        if (out_status !== want.status || out_taken_irq !== want.taken_irq ||
            out_taken_valid !== want.taken_valid) begin
          mismatches <= mismatches + 1;
          $display("%0t mismatch: expected status %0d irq %0d valid %0d, actual %0d %0d %0d",
                   $time, want.status, want.taken_irq, want.taken_valid, out_status,
                   out_taken_irq, out_taken_valid);
        end
      end
    end
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  initial begin
    int          i;
    int          phase;
    int          pick;
    logic [2:0]  act;
    logic [6:0]  irq;
    logic        mark;
    irq_result_t res;

    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_action       <= ACT_ENABLE;
    in_irq_number   <= '0;
    in_mark_pending <= 1'b0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    allowed_vec     = '0;
    mask_vec        = '1;
    pending_vec     = '0;

    plan = '{
      '{ACT_TAKE,    7'd0,   1'b0, 1'b1, '{ST_NONE,  7'd0, 1'b0}},
      '{ACT_MASK,    7'd0,   1'b1, 1'b1, '{ST_GROUP, 7'd0, 1'b0}},
      '{ACT_UNMASK,  7'd95,  1'b0, 1'b1, '{ST_GROUP, 7'd0, 1'b0}},
      '{ACT_ENABLE,  7'd96,  1'b0, 1'b1, '{ST_RANGE, 7'd0, 1'b0}},
      '{ACT_DISABLE, 7'd127, 1'b1, 1'b1, '{ST_RANGE, 7'd0, 1'b0}},
      '{ACT_MASK,    7'd100, 1'b1, 1'b1, '{ST_RANGE, 7'd0, 1'b0}},
      '{ACT_UNMASK,  7'd127, 1'b0, 1'b1, '{ST_RANGE, 7'd0, 1'b0}},
      '{ACT_ENABLE,  7'd0,   1'b1, 1'b0, '{ST_OK,    7'd0, 1'b0}},
      '{ACT_MASK,    7'd0,   1'b1, 1'b0, '{ST_OK,    7'd0, 1'b0}},
      '{ACT_MASK,    7'd31,  1'b1, 1'b0, '{ST_OK,    7'd0, 1'b0}},
      '{ACT_MASK,    7'd32,  1'b1, 1'b1, '{ST_GROUP, 7'd0, 1'b0}},
      '{ACT_ENABLE,  7'd95,  1'b0, 1'b0, '{ST_OK,    7'd0, 1'b0}},
      '{ACT_MASK,    7'd95,  1'b1, 1'b0, '{ST_OK,    7'd0, 1'b0}},
      '{ACT_MASK,    7'd64,  1'b0, 1'b0, '{ST_OK,    7'd0, 1'b0}},
      '{ACT_UNMASK,  7'd64,  1'b1, 1'b0, '{ST_OK,    7'd0, 1'b0}},
      '{ACT_TAKE,    7'd127, 1'b1, 1'b0, '{ST_OK,    7'd0, 1'b0}},
      '{ACT_TAKE,    7'd0,   1'b0, 1'b0, '{ST_OK,    7'd0, 1'b0}},
      '{ACT_TAKE,    7'd64,  1'b1, 1'b0, '{ST_OK,    7'd0, 1'b0}},
      '{ACT_TAKE,    7'd0,   1'b0, 1'b0, '{ST_OK,    7'd0, 1'b0}},
      '{ActSpareLo,  7'd127, 1'b1, 1'b1, '{ST_OK,    7'd0, 1'b0}},
      '{ActSpareHi,  7'd0,   1'b1, 1'b1, '{ST_OK,    7'd0, 1'b0}},
      '{ACT_DISABLE, 7'd0,   1'b0, 1'b0, '{ST_OK,    7'd0, 1'b0}},
      '{ACT_MASK,    7'd1,   1'b1, 1'b0, '{ST_OK,    7'd0, 1'b0}},
      '{ACT_ENABLE,  7'd63,  1'b1, 1'b0, '{ST_OK,    7'd0, 1'b0}},
      '{ACT_TAKE,    7'd0,   1'b0, 1'b0, '{ST_OK,    7'd0, 1'b0}}
    };

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < PlanLen; i++) begin
      res = arbitrate(plan[i].act, plan[i].irq, plan[i].mark);
      if (plan[i].typed) res = plan[i].res;
      send_word(plan[i].act, plan[i].irq, plan[i].mark, res);
    end

    // Mostly mask-with-pending and take, so the pending vector fills and drains.
    for (phase = 0; phase < 4; phase++) begin
      send_idle_pct  = (phase == 1) ? 52 : (phase == 3) ? 35 : 0;
      recv_stall_pct = (phase == 2) ? 52 : (phase == 3) ? 35 : 0;
      for (i = 0; i < PhaseLen; i++) begin
        pick = $urandom_range(99);
        if (pick < 20) act = ACT_ENABLE;
        else if (pick < 28) act = ACT_DISABLE;
        else if (pick < 58) act = ACT_MASK;
        else if (pick < 70) act = ACT_UNMASK;
        else if (pick < 95) act = ACT_TAKE;
        else act = 3'($urandom_range(ActSpareHi, ActSpareLo));
        if ($urandom_range(99) < 85) irq = 7'($urandom_range(SrcCount - 1));
        else irq = 7'($urandom_range(IrqMax, SrcCount));
        mark = ($urandom_range(99) < 75);
        res  = arbitrate(act, irq, mark);
        send_word(act, irq, mark, res);
      end
    end
    in_valid <= 1'b0;

    while (result_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/ipa_pkg.sv
design/interrupt_pending_arbiter.sv
design/ipa_checker.sv
sim/interrupt_pending_arbiter_tb.sv
